// ----- hw/rtl/tlpt_pkg.sv -----
// shared types and constants of the two-level page table updater
// no dependencies; used by the controller, datapath and top level
`default_nettype none

package tlpt_pkg;

  localparam int DIR_ENTRIES = 1024;

  localparam logic [1:0] CMD_MAP     = 2'd0;
  localparam logic [1:0] CMD_UNMAP   = 2'd1;
  localparam logic [1:0] CMD_SETPERM = 2'd2;
  localparam logic [1:0] CMD_INVAL   = 2'd3;

  localparam logic [1:0] STAT_OK          = 2'd0;
  localparam logic [1:0] STAT_NOT_PRESENT = 2'd1;
  localparam logic [1:0] STAT_POOL_FULL   = 2'd2;
  localparam logic [1:0] STAT_RANGE       = 2'd3;

  localparam logic [11:0] PDE_NEW_FLAGS = 12'h007;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_SETUP, ST_RANGE, ST_DIR_RD, ST_DIR_CHK, ST_SCAN_RD,
    ST_SCAN_CHK, ST_ENT_RD, ST_ENT_WR, ST_DIR_END, ST_NEXT, ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_CLEAR, OP_LOAD, OP_TOTAL, OP_RANGE, OP_DIR_RD, OP_DIR_CHK,
    OP_SCAN_RD, OP_SCAN_CHK, OP_ENT_RD, OP_ENT_WR, OP_DIR_END, OP_NEXT, OP_EMIT
  } op_t;

  typedef struct packed {
    logic clr_last;
    logic len_zero;
    logic range_bad;
    logic need_alloc;
    logic resolved;
    logic absent_fail;
    logic slot_free;
    logic scan_last;
    logic first_bad;
    logic ent_last;
    logic dir_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tlpt_req_if.sv -----
// command channel: valid/ready plus one command item
// no dependencies
`default_nettype none

interface tlpt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] virt_addr;
  logic [31:0] length_bytes;
  logic [31:0] phys_addr;
  logic [11:0] perm_flags;

  modport source (output valid, cmd, virt_addr, length_bytes, phys_addr, perm_flags,
                  input ready);
  modport sink (input valid, cmd, virt_addr, length_bytes, phys_addr, perm_flags,
                output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tlpt_rsp_if.sv -----
// result channel: valid/ready plus one result item
// no dependencies
`default_nettype none

interface tlpt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] first_entry;
  logic [20:0] released_pages;

  modport source (output valid, status, first_entry, released_pages, input ready);
  modport sink (input valid, status, first_entry, released_pages, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tlpt_cfg_if.sv -----
// configuration write channel for the table pool base frame
// no dependencies
`default_nettype none

interface tlpt_cfg_if;
  logic        valid;
  logic        ready;
  logic [19:0] table_pool_frame;

  modport source (output valid, table_pool_frame, input ready);
  modport sink (input valid, table_pool_frame, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tlpt_ctl.sv -----
// sequencing state machine of the page table updater
// depends on tlpt_pkg; drives datapath ops from datapath status
`default_nettype none

module tlpt_ctl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire tlpt_pkg::dp_status_t st,
  output tlpt_pkg::op_t            op
);

  tlpt_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlpt_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tlpt_pkg::ST_CLEAR:    if (st.clr_last) state_next = tlpt_pkg::ST_IDLE;
      tlpt_pkg::ST_IDLE:     if (in_valid) state_next = tlpt_pkg::ST_SETUP;
      tlpt_pkg::ST_SETUP: begin
        state_next = st.len_zero ? tlpt_pkg::ST_DONE : tlpt_pkg::ST_RANGE;
      end
      tlpt_pkg::ST_RANGE: begin
        state_next = st.range_bad ? tlpt_pkg::ST_DONE : tlpt_pkg::ST_DIR_RD;
      end
      tlpt_pkg::ST_DIR_RD:   state_next = tlpt_pkg::ST_DIR_CHK;
      tlpt_pkg::ST_DIR_CHK: begin
        if (st.need_alloc) begin
          state_next = tlpt_pkg::ST_SCAN_RD;
        end else if (!st.resolved) begin
          state_next = st.absent_fail ? tlpt_pkg::ST_DONE : tlpt_pkg::ST_NEXT;
        end else begin
          state_next = tlpt_pkg::ST_ENT_RD;
        end
      end
      tlpt_pkg::ST_SCAN_RD:  state_next = tlpt_pkg::ST_SCAN_CHK;
      tlpt_pkg::ST_SCAN_CHK: begin
        if (st.slot_free) begin
          state_next = tlpt_pkg::ST_ENT_RD;
        end else if (st.scan_last) begin
          state_next = tlpt_pkg::ST_DONE;
        end else begin
          state_next = tlpt_pkg::ST_SCAN_RD;
        end
      end
      tlpt_pkg::ST_ENT_RD:   state_next = tlpt_pkg::ST_ENT_WR;
      tlpt_pkg::ST_ENT_WR: begin
        if (st.first_bad) begin
          state_next = tlpt_pkg::ST_DONE;
        end else if (st.ent_last) begin
          state_next = tlpt_pkg::ST_DIR_END;
        end else begin
          state_next = tlpt_pkg::ST_ENT_RD;
        end
      end
      tlpt_pkg::ST_DIR_END:  state_next = tlpt_pkg::ST_NEXT;
      tlpt_pkg::ST_NEXT: begin
        state_next = st.dir_last ? tlpt_pkg::ST_DONE : tlpt_pkg::ST_DIR_RD;
      end
      tlpt_pkg::ST_DONE:     if (st.out_free) state_next = tlpt_pkg::ST_IDLE;
      default:               state_next = tlpt_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    op       = tlpt_pkg::OP_NONE;
    case (state)
      tlpt_pkg::ST_CLEAR:    op = tlpt_pkg::OP_CLEAR;
      tlpt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) op = tlpt_pkg::OP_LOAD;
      end
      tlpt_pkg::ST_SETUP:    op = tlpt_pkg::OP_TOTAL;
      tlpt_pkg::ST_RANGE:    op = tlpt_pkg::OP_RANGE;
      tlpt_pkg::ST_DIR_RD:   op = tlpt_pkg::OP_DIR_RD;
      tlpt_pkg::ST_DIR_CHK:  op = tlpt_pkg::OP_DIR_CHK;
      tlpt_pkg::ST_SCAN_RD:  op = tlpt_pkg::OP_SCAN_RD;
      tlpt_pkg::ST_SCAN_CHK: op = tlpt_pkg::OP_SCAN_CHK;
      tlpt_pkg::ST_ENT_RD:   op = tlpt_pkg::OP_ENT_RD;
      tlpt_pkg::ST_ENT_WR:   op = tlpt_pkg::OP_ENT_WR;
      tlpt_pkg::ST_DIR_END:  op = tlpt_pkg::OP_DIR_END;
      tlpt_pkg::ST_NEXT:     op = tlpt_pkg::OP_NEXT;
      tlpt_pkg::ST_DONE:     if (st.out_free) op = tlpt_pkg::OP_EMIT;
      default:               op = tlpt_pkg::OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/tlpt_dp.sv -----
// datapath: directory, table pool and slot map memories, walk counters
// and the result register; depends on tlpt_pkg, driven by tlpt_ctl
`default_nettype none

module tlpt_dp #(
  parameter int TABLE_SLOTS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire tlpt_pkg::op_t        op,
  output tlpt_pkg::dp_status_t      st,
  input  wire logic                 cfg_valid,
  input  wire logic [19:0]          cfg_frame,
  input  wire logic [1:0]           cmd,
  input  wire logic [31:0]          virt_addr,
  input  wire logic [31:0]          length_bytes,
  input  wire logic [31:0]          phys_addr,
  input  wire logic [11:0]          perm_flags,
  output logic                      rsp_valid,
  input  wire logic                 rsp_ready,
  output logic [1:0]                status,
  output logic [31:0]               first_entry,
  output logic [20:0]               released_pages
);

  localparam int SW        = $clog2(TABLE_SLOTS);
  localparam int TAW       = SW + 10;
  localparam int TBL_DEPTH = TABLE_SLOTS * tlpt_pkg::DIR_ENTRIES;

  logic [31:0] dir_mem [0:tlpt_pkg::DIR_ENTRIES-1];
  logic [31:0] tbl_mem [0:TBL_DEPTH-1];
  logic        used_mem [0:TABLE_SLOTS-1];

  logic [31:0]    dir_q, tbl_q;
  logic           used_q;
  logic [TAW-1:0] clr;
  logic [19:0]    pool;

  logic [1:0]   cmd_r;
  logic [31:0]  len_r;
  logic [9:0]   dir_idx, pg_idx, i, seg_start;
  logic [19:0]  frame;
  logic [11:0]  flags;
  logic [20:0]  total;
  logic [10:0]  pde_num, seg_end, j;
  logic [31:0]  pde;
  logic [SW-1:0] slot, sc;
  logic [20:0]  released;
  logic [31:0]  first;
  logic [1:0]   stat;

  // combinational helpers
  logic [20:0]    pte_num;
  logic [21:0]    total_round;
  logic [10:0]    pde_num_c;
  logic [9:0]     d;
  logic [19:0]    diff;
  logic           resolved, clear_cmd, is_map, first_chk, full_seg, dir_last;
  logic [31:0]    new_pde;
  logic           dir_we, tbl_we, used_we, used_wdata;
  logic [9:0]     dir_addr;
  logic [TAW-1:0] tbl_addr;
  logic [SW-1:0]  used_addr;
  logic [31:0]    dir_wdata, tbl_wdata;

  assign pte_num     = {1'b0, len_r[31:12]} + {20'd0, |len_r[11:0]};
  assign total_round = {1'b0, total} + 22'd1023;
  assign pde_num_c   = total_round[20:10];
  assign d           = dir_idx + i;
  assign diff        = dir_q[31:12] - pool;
  assign resolved    = dir_q[0] && (diff != 20'd0) && (diff < 20'(TABLE_SLOTS));
  assign is_map      = (cmd_r == tlpt_pkg::CMD_MAP);
  assign clear_cmd   = (cmd_r == tlpt_pkg::CMD_UNMAP) || (cmd_r == tlpt_pkg::CMD_INVAL);
  assign first_chk   = clear_cmd && (i == 10'd0) && (j == {1'b0, seg_start});
  assign full_seg    = (seg_start == 10'd0) && (seg_end == 11'd1024);
  assign dir_last    = ({1'b0, i} + 11'd1) == pde_num;
  assign new_pde     = {pool + 20'(sc), tlpt_pkg::PDE_NEW_FLAGS};

  always_comb begin
    st.clr_last    = (clr == TAW'(TBL_DEPTH - 1));
    st.len_zero    = (len_r == 32'd0);
    st.range_bad   = ({2'b0, dir_idx} + {1'b0, pde_num_c}) > 12'd1024;
    st.need_alloc  = is_map && !dir_q[0];
    st.resolved    = resolved;
    st.absent_fail = clear_cmd && (i == 10'd0) && !resolved;
    st.slot_free   = !used_q;
    st.scan_last   = (sc == SW'(TABLE_SLOTS - 1));
    st.first_bad   = first_chk && !tbl_q[0];
    st.ent_last    = (j + 11'd1) == seg_end;
    st.dir_last    = dir_last;
    st.out_free    = !rsp_valid || rsp_ready;
  end

  // memory ports
  always_comb begin
    dir_we     = 1'b0;
    dir_wdata  = '0;
    tbl_we     = 1'b0;
    tbl_wdata  = '0;
    used_we    = 1'b0;
    used_wdata = 1'b0;
    dir_addr   = d;
    tbl_addr   = {slot, j[9:0]};
    used_addr  = sc;
    case (op)
      tlpt_pkg::OP_CLEAR: begin
        dir_addr   = clr[9:0];
        tbl_addr   = clr;
        used_addr  = clr[SW-1:0];
        tbl_we     = 1'b1;
        dir_we     = (clr[TAW-1:10] == '0);
        used_we    = (clr < TAW'(TABLE_SLOTS));
        used_wdata = (clr == '0);
      end
      tlpt_pkg::OP_SCAN_CHK: begin
        if (!used_q) begin
          used_we    = 1'b1;
          used_wdata = 1'b1;
          dir_we     = 1'b1;
          dir_wdata  = new_pde;
        end
      end
      tlpt_pkg::OP_ENT_WR: begin
        if (!(first_chk && !tbl_q[0])) begin
          tbl_we = 1'b1;
          if (is_map) begin
            tbl_wdata = {frame, flags};
          end else if (cmd_r == tlpt_pkg::CMD_SETPERM) begin
            tbl_wdata = tbl_q | {20'd0, flags};
          end else begin
            tbl_wdata = '0;
          end
        end
      end
      tlpt_pkg::OP_DIR_END: begin
        used_addr = slot;
        if (clear_cmd && full_seg) begin
          dir_we = 1'b1;
          if (cmd_r == tlpt_pkg::CMD_UNMAP) begin
            dir_wdata = '0;
            used_we   = 1'b1;
          end else begin
            dir_wdata = {pde[31:1], 1'b0};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (dir_we) dir_mem[dir_addr] <= dir_wdata;
    dir_q <= dir_mem[dir_addr];
  end

  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_addr] <= tbl_wdata;
    tbl_q <= tbl_mem[tbl_addr];
  end

  always_ff @(posedge clk) begin
    if (used_we) used_mem[used_addr] <= used_wdata;
    used_q <= used_mem[used_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr       <= '0;
      pool      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_valid) pool <= cfg_frame;
      if (op == tlpt_pkg::OP_CLEAR) clr <= clr + TAW'(1);
      if (op == tlpt_pkg::OP_EMIT) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    case (op)
      tlpt_pkg::OP_LOAD: begin
        cmd_r     <= cmd;
        len_r     <= length_bytes;
        dir_idx   <= virt_addr[31:22];
        pg_idx    <= virt_addr[21:12];
        frame     <= phys_addr[31:12];
        flags     <= perm_flags;
        released  <= '0;
        first     <= '0;
        stat      <= tlpt_pkg::STAT_OK;
        i         <= '0;
      end
      tlpt_pkg::OP_TOTAL: total <= pte_num + {11'd0, pg_idx};
      tlpt_pkg::OP_RANGE: begin
        pde_num <= pde_num_c;
        if (st.range_bad) stat <= tlpt_pkg::STAT_RANGE;
      end
      tlpt_pkg::OP_DIR_RD: begin
        seg_start <= (i == 10'd0) ? pg_idx : 10'd0;
        seg_end   <= (dir_last && (total[9:0] != 10'd0)) ? {1'b0, total[9:0]} : 11'd1024;
      end
      tlpt_pkg::OP_DIR_CHK: begin
        pde  <= dir_q;
        sc   <= SW'(1);
        slot <= diff[SW-1:0];
        j    <= {1'b0, seg_start};
        if (!st.need_alloc && !resolved) begin
          if (st.absent_fail) begin
            stat <= tlpt_pkg::STAT_NOT_PRESENT;
          end else begin
            // table absent: skip its pages but keep the frame in step
            frame <= frame + 20'(seg_end - {1'b0, seg_start});
          end
        end
      end
      tlpt_pkg::OP_SCAN_CHK: begin
        if (!used_q) begin
          slot <= sc;
        end else if (st.scan_last) begin
          stat <= tlpt_pkg::STAT_POOL_FULL;
        end else begin
          sc <= sc + SW'(1);
        end
      end
      tlpt_pkg::OP_ENT_WR: begin
        if (first_chk) first <= tbl_q;
        if (first_chk && !tbl_q[0]) begin
          stat <= tlpt_pkg::STAT_NOT_PRESENT;
        end else begin
          if (clear_cmd && tbl_q[0]) released <= released + 21'd1;
          if (is_map) frame <= frame + 20'd1;
          j <= j + 11'd1;
        end
      end
      tlpt_pkg::OP_NEXT: i <= i + 10'd1;
      tlpt_pkg::OP_EMIT: begin
        status         <= stat;
        first_entry    <= first;
        released_pages <= released;
      end
      default: ;
    endcase
  end

  // the directory's own slot is never handed out or freed
  a_alloc_not_dir: assert property (@(posedge clk) disable iff (rst)
    (op == tlpt_pkg::OP_SCAN_CHK) |-> (sc != '0))
    else $error("slot scan reached the directory slot");

  a_free_not_dir: assert property (@(posedge clk) disable iff (rst)
    (used_we && (op == tlpt_pkg::OP_DIR_END)) |-> (slot != '0) && !used_wdata)
    else $error("unmap freed the directory slot");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (op == tlpt_pkg::OP_NEXT) |-> ({1'b0, i} < pde_num))
    else $error("directory walk ran past its range");

  a_fail_no_count: assert property (@(posedge clk) disable iff (rst)
    (op == tlpt_pkg::OP_EMIT && stat != tlpt_pkg::STAT_OK) |=> (released_pages == '0))
    else $error("failed command reports released pages");

endmodule

`default_nettype wire

// ----- hw/rtl/two_level_page_table_updater.sv -----
// Two-level i386 page table updater: keeps a 1024-entry page directory and
// a pool of TABLE_SLOTS table slots (slot 0 is never handed out) in on-chip
// memory and applies map, unmap, set-permission and invalidate commands over
// a virtual range, one result per command. After reset a clearing pass zeroes
// the memories; commands are held off until it ends (configuration writes are
// taken at any time). A command is accepted, its range set up and checked,
// then walked one page entry at a time through the single table memory port,
// a read then a write, after a read and check of each directory entry touched
// (an entry whose table is absent is skipped); map first scans the pool slots
// when it must allocate a table. The result is then emitted. Zero-length and
// out-of-range commands end before the walk.
// depends on tlpt_pkg, the channel interfaces, tlpt_ctl and tlpt_dp
`default_nettype none

module two_level_page_table_updater #(
  parameter int TABLE_SLOTS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  tlpt_req_if.sink   req,
  tlpt_rsp_if.source rsp,
  tlpt_cfg_if.sink   cfg
);

  tlpt_pkg::op_t        op;
  tlpt_pkg::dp_status_t st;
  logic                 in_ready;

  assign req.ready = in_ready;
  assign cfg.ready = 1'b1;

  tlpt_ctl u_ctl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .st       (st),
    .op       (op)
  );

  tlpt_dp #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .op             (op),
    .st             (st),
    .cfg_valid      (cfg.valid),
    .cfg_frame      (cfg.table_pool_frame),
    .cmd            (req.cmd),
    .virt_addr      (req.virt_addr),
    .length_bytes   (req.length_bytes),
    .phys_addr      (req.phys_addr),
    .perm_flags     (req.perm_flags),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .status         (rsp.status),
    .first_entry    (rsp.first_entry),
    .released_pages (rsp.released_pages)
  );

endmodule

`default_nettype wire

// ----- bench/tlpt_tb_if.sv -----
// no extra interfaces are needed: the bench uses the channel interfaces of the rtl
// depends on tlpt_req_if, tlpt_rsp_if, tlpt_cfg_if
`timescale 1ns / 100ps

// ----- bench/two_level_page_table_updater_tb.sv -----
// testbench of the two-level page table updater: directed table then random commands
// results checked against a behavioral page-table predictor or a row's known result;
// depends on tlpt_pkg and the request, result and configuration channel interfaces
`timescale 1ns / 100ps

module two_level_page_table_updater_tb;

  localparam int SLOTS = 16;
  localparam int LIMIT = 80000000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] va;
    logic [31:0] len;
    logic [31:0] pa;
    logic [11:0] flags;
  } page_cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] first_entry;
    logic [20:0] released;
  } page_res_t;

  typedef struct {
    page_cmd_t c;
    bit        known;
    page_res_t r;
  } dir_row_t;

  logic clk = 0;
  logic rst = 1;
  tlpt_req_if req ();
  tlpt_rsp_if rsp ();
  tlpt_cfg_if cfg ();

  two_level_page_table_updater #(.TABLE_SLOTS(SLOTS)) DUT (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink));

  // predictor state
  logic [31:0] pdir [1024];
  logic [31:0] ptbl [SLOTS*1024];
  bit          pused [SLOTS];
  logic [19:0] pool_base;

  page_res_t expected_q[$];
  page_res_t known_q[$];
  bit        known_flag_q[$];
  int        errors = 0;
  int        n_sent = 0;
  int        n_seen = 0;
  int        cycles = 0;
  bit        calm = 0;
  int        map_cnt = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int lookup_slot(logic [31:0] pde);
    logic [19:0] s;
    if (!pde[0]) return -1;
    s = pde[31:12] - pool_base;
    if (s == 0 || s >= SLOTS) return -1;
    return int'(s);
  endfunction

  function automatic page_res_t apply_page_cmd(page_cmd_t c);
    page_res_t r;
    logic [31:0] pnum, pidx, didx, total, dnum, frame, rel, d, st, en;
    int s;
    r = '0;
    rel = 0;
    frame = {12'b0, c.pa[31:12]};
    if (c.len == 0) return r;
    pnum = (c.len >> 12) + (c.len[11:0] != 0);
    pidx = (c.va >> 12) & 32'h3ff;
    didx = c.va >> 22;
    total = pnum + pidx;
    dnum = (total + 1023) >> 10;
    if (didx + dnum > 1024) begin
      r.status = tlpt_pkg::STAT_RANGE;
      return r;
    end
    for (logic [31:0] i = 0; i < dnum; i++) begin
      d = didx + i;
      st = (i == 0) ? pidx : 0;
      en = 1024;
      if (i == dnum - 1 && total[9:0] != 0) en = total & 32'h3ff;
      if (c.cmd == tlpt_pkg::CMD_MAP && !pdir[d][0]) begin
        s = -1;
        for (int k = 1; k < SLOTS; k++)
          if (s < 0 && !pused[k]) s = k;
        if (s < 0) begin
          r.status = tlpt_pkg::STAT_POOL_FULL;
          return r;
        end
        pused[s] = 1;
        pdir[d] = {pool_base + 20'(s), tlpt_pkg::PDE_NEW_FLAGS};
      end
      s = lookup_slot(pdir[d]);
      if (s < 0) begin
        if ((c.cmd == tlpt_pkg::CMD_UNMAP || c.cmd == tlpt_pkg::CMD_INVAL) && i == 0) begin
          r.status = tlpt_pkg::STAT_NOT_PRESENT;
          return r;
        end
        frame += en - st;
        continue;
      end
      if (c.cmd == tlpt_pkg::CMD_MAP) begin
        for (logic [31:0] j = st; j < en; j++) begin
          ptbl[s*1024 + j] = {frame[19:0], c.flags};
          frame++;
        end
      end else if (c.cmd == tlpt_pkg::CMD_SETPERM) begin
        for (logic [31:0] j = st; j < en; j++)
          ptbl[s*1024 + j] |= {20'b0, c.flags};
      end else begin
        if (i == 0) begin
          r.first_entry = ptbl[s*1024 + st];
          if (!r.first_entry[0]) begin
            r.status = tlpt_pkg::STAT_NOT_PRESENT;
            return r;
          end
        end
        for (logic [31:0] j = st; j < en; j++) begin
          if (ptbl[s*1024 + j][0]) rel++;
          ptbl[s*1024 + j] = 0;
        end
        if (st == 0 && en == 1024) begin
          if (c.cmd == tlpt_pkg::CMD_UNMAP) begin
            pdir[d] = 0;
            pused[s] = 0;
          end else pdir[d][0] = 1'b0;
        end
      end
    end
    r.released = rel[20:0];
    return r;
  endfunction

  // result side: random stall bursts, checks in order
  int stall_left = 0;
  always @(posedge clk) begin
    page_res_t e, got;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = {rsp.status, rsp.first_entry, rsp.released_pages};
        n_seen <= n_seen + 1;
        if (expected_q.size() == 0) begin
          $error("result with nothing expected");
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (known_flag_q.pop_front()) e = known_q.pop_front();
          if (got.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, got.status);
            errors++;
          end
          if (got.first_entry !== e.first_entry) begin
            $error("first_entry exp %h got %h", e.first_entry, got.first_entry);
            errors++;
          end
          if (got.released !== e.released) begin
            $error("released_pages exp %0d got %0d", e.released, got.released);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        rsp.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 2);
        rsp.ready <= 1'b0;
      end else rsp.ready <= 1'b1;
    end
  end

  // valid stays high into the next command unless an idle burst drops it
  task automatic send_cmd(page_cmd_t c, bit known, page_res_t kr);
    page_res_t p;
    if (!calm && $urandom_range(0, 4) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req.cmd <= c.cmd;
    req.virt_addr <= c.va;
    req.length_bytes <= c.len;
    req.phys_addr <= c.pa;
    req.perm_flags <= c.flags;
    req.valid <= 1'b1;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    p = apply_page_cmd(c);
    expected_q.push_back(p);
    known_flag_q.push_back(known);
    if (known) known_q.push_back(kr);
    if (c.cmd == tlpt_pkg::CMD_MAP) map_cnt++;
    n_sent++;
  endtask

  task automatic drain;
    req.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_pool_base(logic [19:0] v);
    cfg.table_pool_frame <= v;
    cfg.valid <= 1'b1;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    pool_base = v;
    cfg.valid <= 1'b0;
  endtask

  function automatic page_cmd_t rand_cmd();
    page_cmd_t c;
    int k;
    c.cmd = 2'($urandom_range(0, 3));
    k = $urandom_range(0, 19);
    // mostly short ranges in a few directory entries so that commands hit mapped pages
    c.va = {8'($urandom_range(0, 3) + 8'hc0 * (k == 0)), 2'($urandom), 10'($urandom),
            12'($urandom)};
    if (k == 1) c.va = $urandom;
    if (k < 2) c.len = $urandom;
    else if (k < 4) c.len = 0;
    else if (k < 6) c.len = $urandom_range(4096, 4096 * 1100);
    else c.len = $urandom_range(1, 4096 * 24);
    c.pa = $urandom;
    c.flags = (c.cmd == tlpt_pkg::CMD_MAP) ? {11'($urandom), 1'b1} : 12'($urandom);
    if ($urandom_range(0, 9) == 0) c.flags = 12'($urandom);
    return c;
  endfunction

  dir_row_t rows[$];
  page_res_t z;

  initial begin
    page_cmd_t c;
    page_res_t nz;
    req.valid = 0; req.cmd = tlpt_pkg::CMD_MAP; req.virt_addr = 0; req.length_bytes = 0;
    req.phys_addr = 0; req.perm_flags = 0;
    cfg.valid = 0; cfg.table_pool_frame = 0;
    for (int i = 0; i < 1024; i++) pdir[i] = 0;
    for (int i = 0; i < SLOTS*1024; i++) ptbl[i] = 0;
    for (int i = 0; i < SLOTS; i++) pused[i] = (i == 0);
    pool_base = 0;
    z = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_pool_base(20'hfffff);
    nz = z; nz.status = tlpt_pkg::STAT_NOT_PRESENT;
    rows = '{
      '{'{tlpt_pkg::CMD_UNMAP, 32'h0, 32'h1000, 32'h0, 12'h0}, 1, nz},
      '{'{tlpt_pkg::CMD_INVAL, 32'h0, 32'h1000, 32'h0, 12'h0}, 1, nz},
      '{'{tlpt_pkg::CMD_MAP, 32'h0, 32'h0, 32'hffff_ffff, 12'hfff}, 1, z},
      '{'{tlpt_pkg::CMD_MAP, 32'hffc0_0000, 32'h0040_0001, 32'h0, 12'h1}, 1,
        page_res_t'({tlpt_pkg::STAT_RANGE, 32'h0, 21'h0})},
      '{'{tlpt_pkg::CMD_SETPERM, 32'hffff_f000, 32'hffff_ffff, 32'h0, 12'hfff}, 1,
        page_res_t'({tlpt_pkg::STAT_RANGE, 32'h0, 21'h0})},
      '{'{tlpt_pkg::CMD_MAP, 32'h0000_0000, 32'h0000_1001, 32'hffff_ffff, 12'hfff}, 0, z},
      '{'{tlpt_pkg::CMD_MAP, 32'hffff_f000, 32'h1000, 32'h1234_5000, 12'h003}, 0, z},
      '{'{tlpt_pkg::CMD_SETPERM, 32'h0, 32'h2000, 32'h0, 12'h800}, 0, z},
      '{'{tlpt_pkg::CMD_UNMAP, 32'h1000, 32'h1, 32'h0, 12'h0}, 0, z},
      '{'{tlpt_pkg::CMD_UNMAP, 32'h1000, 32'h1, 32'h0, 12'h0}, 0, z},
      '{'{tlpt_pkg::CMD_MAP, 32'h0030_0000, 32'h0020_0000, 32'h8000_0000, 12'h007}, 0, z},
      '{'{tlpt_pkg::CMD_INVAL, 32'h0040_0000, 32'h0040_0000, 32'h0, 12'h0}, 0, z},
      '{'{tlpt_pkg::CMD_MAP, 32'h0040_0000, 32'h1000, 32'h0, 12'h001}, 0, z},
      '{'{tlpt_pkg::CMD_UNMAP, 32'h0, 32'h0080_0000, 32'h0, 12'h0}, 0, z},
      '{'{tlpt_pkg::CMD_MAP, 32'h0, 32'h0400_0000, 32'h0, 12'h001}, 0, z},
      '{'{tlpt_pkg::CMD_UNMAP, 32'h0, 32'h0400_0000, 32'h0, 12'h0}, 0, z},
      '{'{tlpt_pkg::CMD_INVAL, 32'h0800_0000, 32'h0, 32'h0, 12'h0}, 1, z}
    };
    foreach (rows[i]) send_cmd(rows[i].c, rows[i].known, rows[i].r);
    drain();

    // a pool base that lets old directory entries resolve to slot zero or past the pool
    write_pool_base(20'h00000);
    for (int ph = 0; ph < 6; ph++) begin
      repeat (95) send_cmd(rand_cmd(), 0, z);
      drain();
      if (ph == 2) write_pool_base(20'h80000);
      else if (ph == 4) write_pool_base($urandom);
      else if (ph == 1) write_pool_base(20'hfffff);
      if (ph == 4) calm = 1;
    end
    drain();
    $display("ran %0d commands (%0d maps), %0d results, pool base swept incl. extremes",
             n_sent, map_cnt, n_seen);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
